// ===== rtl/cbcl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank / CHR latch mapper.
// No dependencies; imported by every module of the block.
package cbcl_pkg;

   // Request kinds carried in the mode field
   typedef enum logic [1:0] {
      MODE_CPU_WRITE = 2'd0,
      MODE_CPU_READ  = 2'd1,
      MODE_PPU_ADDR  = 2'd2,
      MODE_CHR_READ  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  open_bus_value;
   } req_type;

   typedef struct packed {
      logic [5:0]  prg_bank;
      logic [7:0]  read_data;
      logic [12:0] chr_address;
      logic        chr_remapped;
   } rsp_type;

   // Register file
   localparam int unsigned CsrAddrWidth  = 3;
   localparam logic        CsrPrgBankLimit = 1'b0;   // word index of the limit register
   localparam logic [5:0]  PrgLimitReset = 6'h3F;

   // Address decode
   localparam logic [5:0]  BankPageHi  = 6'b010100;  // pages 0x50..0x53
   localparam logic [3:0]  MapperWinHi = 4'h5;       // 0x5000..0x5FFF

endpackage

// ===== rtl/cbcl_core.sv =====
`timescale 1ns / 1ps
// Mapper state (bank registers, A13 tracker, A9 latch) and per-request result logic.
// Depends on cbcl_pkg.
module cbcl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  cbcl_pkg::req_type req,
   input  logic [5:0]       prg_bank_limit,
   output cbcl_pkg::rsp_type result
);
   import cbcl_pkg::*;

   logic [7:0] bank_regs_ff [4];
   logic [7:0] bank_regs_in [4];
   logic       latched_a9_ff, latched_a9_in;
   logic       last_a13_ff, last_a13_in;

   logic       a13;
   logic [5:0] bank_raw;
   logic [1:0] bank_low;

   assign a13 = req.address[13];

   // next state
   always_comb begin
      bank_regs_in  = bank_regs_ff;
      latched_a9_in = latched_a9_ff;
      last_a13_in   = last_a13_ff;
      case (req.mode)
         MODE_CPU_WRITE: begin
            if (req.address[15:10] == BankPageHi)
               bank_regs_in[req.address[9:8]] = req.write_data;
         end
         MODE_PPU_ADDR: begin
            if (!last_a13_ff && a13)
               latched_a9_in = req.address[9];
            last_a13_in = a13;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++)
            bank_regs_ff[i] <= '0;
         latched_a9_ff <= 1'b0;
         last_a13_ff   <= 1'b0;
      end else if (accept) begin
         bank_regs_ff  <= bank_regs_in;
         latched_a9_ff <= latched_a9_in;
         last_a13_ff   <= last_a13_in;
      end
   end

   // PRG bank from the updated registers; low bits by reg3 bits 2 and 0
   always_comb begin
      case ({bank_regs_in[3][2], bank_regs_in[3][0]})
         2'b00:   bank_low = {1'b1, bank_regs_in[1][1]};
         2'b01:   bank_low = 2'b11;
         2'b10:   bank_low = {bank_regs_in[0][1], bank_regs_in[1][1]};
         default: bank_low = bank_regs_in[0][1:0];
      endcase
   end

   assign bank_raw = {bank_regs_in[2][1:0], bank_regs_in[0][3:2], bank_low};

   always_comb begin
      result.prg_bank     = (bank_raw > prg_bank_limit) ? (bank_raw & prg_bank_limit)
                                                        : bank_raw;
      result.read_data    = '0;
      result.chr_address  = '0;
      result.chr_remapped = 1'b0;
      case (req.mode)
         MODE_CPU_READ: begin
            if (req.address[15:12] != MapperWinHi)
               result.read_data = req.open_bus_value;
         end
         MODE_CHR_READ: begin
            // mode 3 leaves reg0 and the tracker untouched, so current state is used
            if (bank_regs_ff[0][7] && !last_a13_ff) begin
               result.chr_address  = {latched_a9_ff, req.address[11:0]};
               result.chr_remapped = 1'b1;
            end else begin
               result.chr_address  = req.address[12:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/cartridge_bank_and_chr_latch_mapper_top.sv =====
`timescale 1ns / 1ps
// Top level of the cartridge bank / CHR latch mapper: handshakes, CSR, result register.
// Depends on cbcl_pkg and cbcl_core.
//
//   channel | ports                     | moves
//   --------+---------------------------+------------------------------------
//   req     | req_valid/ready/payload   | one bus event request per handshake
//   rsp     | rsp_valid/ready/payload   | one result per request, in order
//   csr     | psel/penable/pwrite/...   | prg_bank_limit at byte address 0
//
// The decode and bank logic sit between the request inputs and the result register,
// so the result shows the cycle after acceptance, and a new request can be accepted
// every cycle while no untaken result is stalled in the result register.
// req_ready drops only while the result register holds an untaken result.
// Synchronous reset clears the bank registers, the A13 tracker, the A9 latch,
// the result valid flag and sets prg_bank_limit to 63.
module cartridge_bank_and_chr_latch_mapper_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cbcl_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cbcl_pkg::rsp_type                 rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cbcl_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import cbcl_pkg::*;

   logic       accept;
   logic       csr_write;
   logic       csr_hit;
   logic [5:0] prg_limit_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    result;

   // ---- configuration port ----
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CsrAddrWidth-1:2] == CsrPrgBankLimit);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign prdata    = csr_hit ? {26'd0, prg_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_limit_ff <= PrgLimitReset;
      end else if (csr_write) begin
         prg_limit_ff <= pwdata[5:0];
      end
   end

   // ---- request side: blocked only by an untaken result ----
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   cbcl_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_payload),
      .prg_bank_limit (prg_limit_ff),
      .result         (result)
   );

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== rtl/cbcl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the mapper top level, attached by bind.
// Depends on cbcl_pkg and cartridge_bank_and_chr_latch_mapper_top.
module cbcl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cbcl_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbcl_pkg::rsp_type rsp_payload
);
   import cbcl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // requests flow while the result side drains
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request blocked with result side free");

   // CHR fields are zero for anything but a CHR read
   a_chr_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.mode != MODE_CHR_READ |=>
         rsp_valid && rsp_payload.chr_address == '0 && !rsp_payload.chr_remapped)
      else $error("CHR fields set outside CHR read");

   // read data is zero except for CPU reads outside the mapper window
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
         (req_payload.mode != MODE_CPU_READ || req_payload.address[15:12] == MapperWinHi)
         |=> rsp_valid && rsp_payload.read_data == '0)
      else $error("unexpected read data");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cartridge_bank_and_chr_latch_mapper_top cbcl_checker u_cbcl_checker (.*);

// ===== tb/tb_cartridge_bank_and_chr_latch_mapper_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_and_chr_latch_mapper_top.
// Depends on cbcl_pkg and the mapper RTL; needs no files or arguments.
module tb_cartridge_bank_and_chr_latch_mapper_top;
   import cbcl_pkg::*;

   // The run is stopped here if the results stop coming
   localparam int unsigned CycleLimit = 400000;
   // Byte address of the bank limit register (register 0, 4 bytes per register)
   localparam logic [CsrAddrWidth-1:0] LimitAddr = {CsrPrgBankLimit, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Per-cycle odds (percent) that the sender holds back / the receiver stalls
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Mirror of the mapper state, advanced once per accepted request
   logic [5:0]  bank_limit;
   logic [7:0]  bank_regs [4];
   logic        a9_latch;
   logic        a13_prev;

   // Expected results, oldest first
   rsp_type     pending_results [$];

   cartridge_bank_and_chr_latch_mapper_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // 32K bank from the four byte registers; the low two bits follow one of
   // four schemes picked by reg3 bits 2 and 0. Over-limit banks are masked.
   function automatic logic [5:0] current_prg_bank();
      logic [5:0] bank;
      bank = {bank_regs[2][1:0], bank_regs[0][3:2], 2'b00};
      case ({bank_regs[3][2], bank_regs[3][0]})
         2'b00: bank[1:0] = {1'b1, bank_regs[1][1]};
         2'b01: bank[1:0] = 2'b11;
         2'b10: bank[1:0] = {bank_regs[0][1], bank_regs[1][1]};
         default: bank[1:0] = bank_regs[0][1:0];
      endcase
      if (bank > bank_limit)
         bank = bank & bank_limit;
      return bank;
   endfunction

   // Applies one bus event to the mirrored state and returns what the block
   // must answer with
   function automatic rsp_type map_bus_event(req_type r);
      rsp_type res;
      res = '0;
      case (r.mode)
         MODE_CPU_WRITE: begin
            // only pages 0x50..0x53 hit a register
            if (r.address[15:10] == BankPageHi)
               bank_regs[r.address[9:8]] = r.write_data;
         end
         MODE_CPU_READ: begin
            res.read_data = (r.address[15:12] == MapperWinHi) ? 8'h00 : r.open_bus_value;
         end
         MODE_PPU_ADDR: begin
            // A9 is caught on a rising A13; bits 15..14 are don't-care
            if (!a13_prev && r.address[13])
               a9_latch = r.address[9];
            a13_prev = r.address[13];
         end
         default: begin
            // CHR fetch: no tracking here, only the remap decision
            if (bank_regs[0][7] && !a13_prev) begin
               res.chr_address  = {a9_latch, r.address[11:0]};
               res.chr_remapped = 1'b1;
            end else begin
               res.chr_address = r.address[12:0];
            end
         end
      endcase
      res.prg_bank = current_prg_bank();
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_error(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Outputs are sampled at the rising edge, so both handshakes are seen with
   // the values that held just before the edge. A result is always for an
   // earlier request, so checking before predicting is safe.
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_error($sformatf("result with nothing expected: %h", rsp_payload));
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.prg_bank !== want.prg_bank)
                  report_error($sformatf("prg_bank got %0d want %0d",
                                         rsp_payload.prg_bank, want.prg_bank));
               if (rsp_payload.read_data !== want.read_data)
                  report_error($sformatf("read_data got %h want %h",
                                         rsp_payload.read_data, want.read_data));
               if (rsp_payload.chr_address !== want.chr_address)
                  report_error($sformatf("chr_address got %h want %h",
                                         rsp_payload.chr_address, want.chr_address));
               if (rsp_payload.chr_remapped !== want.chr_remapped)
                  report_error($sformatf("chr_remapped got %b want %b",
                                         rsp_payload.chr_remapped, want.chr_remapped));
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(map_bus_event(req_payload));
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers (all called and returning at a falling edge)
   // ---------------------------------------------------------------------

   function automatic req_type make_request(mode_type m, logic [15:0] addr,
                                            logic [7:0] wdata, logic [7:0] obus);
      req_type r;
      r.mode           = m;
      r.address        = addr;
      r.write_data     = wdata;
      r.open_bus_value = obus;
      return r;
   endfunction

   // Holds one request until it is taken. Idle cycles go in front of it;
   // valid is only touched once per falling edge.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending and waits for every expected result, then lets the
   // result pipeline settle
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the transfer completes on pready.
   // The bus then idles before the task returns.
   task automatic csr_access(input logic is_write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= LimitAddr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Only done with the pipe empty; the upper data bits are random noise
   // that the register must drop. Read-back confirms the stored value.
   task automatic set_prg_limit(logic [5:0] value);
      logic [31:0] readback;
      wait_results_drained();
      csr_access(1'b1, {26'($urandom_range(32'h03FF_FFFF)), value}, readback);
      bank_limit = value;
      csr_access(1'b0, '0, readback);
      if (readback[5:0] !== value)
         report_error($sformatf("prg_bank_limit reads %h want %h", readback[5:0], value));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // CPU reads around the mapper window; also shows the reset bank of 2
   task automatic test_cpu_reads();
      send_request(make_request(MODE_CPU_READ, 16'h5000, 8'h00, 8'hFF));
      send_request(make_request(MODE_CPU_READ, 16'h5FFF, 8'hFF, 8'hA5));
      send_request(make_request(MODE_CPU_READ, 16'h4FFF, 8'h00, 8'hFF));
      send_request(make_request(MODE_CPU_READ, 16'h6000, 8'h00, 8'h5A));
      send_request(make_request(MODE_CPU_READ, 16'hFFFF, 8'h00, 8'h00));
   endtask

   // Bank register loads and the four low-bit schemes
   task automatic test_bank_modes();
      send_request(make_request(MODE_CPU_WRITE, 16'h5000, 8'h0D, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h51FF, 8'h00, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5280, 8'h02, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5300, 8'h01, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5301, 8'h04, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5100, 8'hFF, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h53FF, 8'hFF, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5300, 8'h00, 8'h00));
      // writes just outside pages 0x50..0x53 must leave the bank alone
      send_request(make_request(MODE_CPU_WRITE, 16'h4FFF, 8'hFF, 8'h00));
      send_request(make_request(MODE_CPU_WRITE, 16'h5400, 8'hFF, 8'h00));
   endtask

   // A13 tracking, A9 latch and CHR remap
   task automatic test_chr_latch();
      send_request(make_request(MODE_CPU_WRITE, 16'h5000, 8'h80, 8'h00));
      // rising A13 with A9 set; bits 15..14 set too and ignored
      send_request(make_request(MODE_PPU_ADDR, 16'hE200, 8'h00, 8'h00));
      // A13 high: plain fetch
      send_request(make_request(MODE_CHR_READ, 16'h1ABC, 8'h00, 8'h00));
      // a CHR fetch with A13 low must not move the tracker
      send_request(make_request(MODE_CHR_READ, 16'h0000, 8'h00, 8'h00));
      send_request(make_request(MODE_PPU_ADDR, 16'h0000, 8'h00, 8'h00));
      send_request(make_request(MODE_CHR_READ, 16'h0FFF, 8'h00, 8'h00));
      send_request(make_request(MODE_CHR_READ, 16'hF123, 8'h00, 8'h00));
   endtask

   // Bank limit at both extremes and in between
   task automatic test_bank_limit();
      set_prg_limit(6'd0);
      send_request(make_request(MODE_CPU_READ, 16'h0000, 8'h00, 8'h11));
      set_prg_limit(6'd5);
      send_request(make_request(MODE_CPU_WRITE, 16'h5200, 8'h03, 8'h00));
      set_prg_limit(6'd63);
      send_request(make_request(MODE_CPU_READ, 16'h8000, 8'h00, 8'h22));
   endtask

   // Bus events of random kind; most CPU writes aim at the mapper pages and most CPU
   // reads at 0x4000..0x7FFF, with a share of fully random bus events as noise
   function automatic req_type random_request();
      req_type r;
      r.mode           = mode_type'($urandom_range(3));
      r.address        = 16'($urandom_range(16'hFFFF));
      r.write_data     = 8'($urandom_range(8'hFF));
      r.open_bus_value = 8'($urandom_range(8'hFF));
      if ($urandom_range(99) < 75) begin
         case (r.mode)
            MODE_CPU_WRITE: r.address[15:10] = BankPageHi;
            MODE_CPU_READ:  r.address[15:13] = 3'($urandom_range(2, 3));
            default: ;
         endcase
      end
      return r;
   endfunction

   // One idling profile, split in two halves, each after a new random limit
   task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (2) begin
         set_prg_limit(6'($urandom_range(63)));
         repeat (count / 2)
            send_request(random_request());
      end
   endtask

   initial begin
      bank_limit = PrgLimitReset;
      foreach (bank_regs[i])
         bank_regs[i] = '0;
      a9_latch = 1'b0;
      a13_prev = 1'b0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_cpu_reads();
      test_bank_modes();
      test_chr_latch();
      test_bank_limit();
      test_random_phase(0, 0, 300);
      test_random_phase(64, 0, 300);
      test_random_phase(0, 64, 300);
      test_random_phase(29, 29, 300);

      wait_results_drained();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cbcl_pkg.sv
rtl/cbcl_core.sv
rtl/cartridge_bank_and_chr_latch_mapper_top.sv
rtl/cbcl_checker.sv
tb/tb_cartridge_bank_and_chr_latch_mapper_top.sv
